// File: rtl/hptc_pkg.sv
package hptc_pkg;

   localparam int DivBits = 32;

   typedef struct packed {
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
   } temp_coef_type;

   typedef struct packed {
      logic [31:0] p1;
      logic [31:0] p2;
      logic [31:0] p3;
      logic [31:0] p4;
      logic [31:0] p5;
      logic [31:0] p6;
      logic [31:0] p7;
      logic [31:0] p8;
      logic [31:0] p9;
   } pres_coef_type;

   typedef struct packed {
      logic [31:0] h1;
      logic [31:0] h2;
      logic [31:0] h3;
      logic [31:0] h4;
      logic [31:0] h5;
      logic [31:0] h6;
   } hum_coef_type;

   typedef enum logic [2:0] {
      REG_TEMP   = 3'd0,
      REG_PRES_A = 3'd1,
      REG_PRES_B = 3'd2,
      REG_MISC   = 3'd3,
      REG_HUM    = 3'd4
   } reg_index_type;

   function automatic logic [31:0] asr(input logic [31:0] x, input int n);
      asr = 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx12(input logic [11:0] v);
      sx12 = {{20{v[11]}}, v};
   endfunction

   function automatic logic [31:0] sx8(input logic [7:0] v);
      sx8 = {{24{v[7]}}, v};
   endfunction

endpackage

// File: rtl/humidity_pressure_temp_compensation_top.sv
// channel | ports                              | handshake
// req     | req_raw_temp/pres/hum              | start & !busy
// rsp     | rsp_temp_centi/pres_pa/hum_q10/... | rsp_valid, one cycle
// csr     | psel penable pwrite paddr pwdata   | write at access, pready=1
// One beat enters per cycle; busy stays low.
// Pipeline: 11 pre-divide stages, 32 divider stages, 3 post stages.
// Synchronous reset clears valid bits and calibration registers.
// The receiver cannot stall; results appear in input order.
module humidity_pressure_temp_compensation_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [19:0] req_raw_temp,
   input  logic [19:0] req_raw_pres,
   input  logic [15:0] req_raw_hum,
   output logic        rsp_valid,
   output logic [31:0] rsp_temp_centi,
   output logic [31:0] rsp_pres_pa,
   output logic [16:0] rsp_hum_q10,
   output logic        rsp_div_error,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   logic [47:0] temp_ff;
   logic [63:0] pa_ff, pb_ff;
   logic [39:0] misc_ff, hum_ff;
   hptc_pkg::reg_index_type idx;
   assign idx = hptc_pkg::reg_index_type'(paddr[5:3]);

   assign pready = 1'b1;
   assign busy   = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff <= '0; pa_ff <= '0; pb_ff <= '0; misc_ff <= '0; hum_ff <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (idx)
            hptc_pkg::REG_TEMP:   temp_ff <= pwdata[47:0];
            hptc_pkg::REG_PRES_A: pa_ff   <= pwdata;
            hptc_pkg::REG_PRES_B: pb_ff   <= pwdata;
            hptc_pkg::REG_MISC:   misc_ff <= pwdata[39:0];
            hptc_pkg::REG_HUM:    hum_ff  <= pwdata[39:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         hptc_pkg::REG_TEMP:   prdata = {16'd0, temp_ff};
         hptc_pkg::REG_PRES_A: prdata = pa_ff;
         hptc_pkg::REG_PRES_B: prdata = pb_ff;
         hptc_pkg::REG_MISC:   prdata = {24'd0, misc_ff};
         hptc_pkg::REG_HUM:    prdata = {24'd0, hum_ff};
         default:              prdata = '0;
      endcase
   end

   hptc_pkg::temp_coef_type tc;
   hptc_pkg::pres_coef_type pc;
   hptc_pkg::hum_coef_type  hc;
   always_comb begin
      tc.t1 = {16'd0, temp_ff[15:0]};
      tc.t2 = hptc_pkg::sx16(temp_ff[31:16]);
      tc.t3 = hptc_pkg::sx16(temp_ff[47:32]);
      pc.p1 = {16'd0, pa_ff[15:0]};
      pc.p2 = hptc_pkg::sx16(pa_ff[31:16]);
      pc.p3 = hptc_pkg::sx16(pa_ff[47:32]);
      pc.p4 = hptc_pkg::sx16(pa_ff[63:48]);
      pc.p5 = hptc_pkg::sx16(pb_ff[15:0]);
      pc.p6 = hptc_pkg::sx16(pb_ff[31:16]);
      pc.p7 = hptc_pkg::sx16(pb_ff[47:32]);
      pc.p8 = hptc_pkg::sx16(pb_ff[63:48]);
      pc.p9 = hptc_pkg::sx16(misc_ff[15:0]);
      hc.h1 = {24'd0, misc_ff[23:16]};
      hc.h3 = {24'd0, misc_ff[31:24]};
      hc.h6 = hptc_pkg::sx8(misc_ff[39:32]);
      hc.h2 = hptc_pkg::sx16(hum_ff[15:0]);
      hc.h4 = hptc_pkg::sx12(hum_ff[27:16]);
      hc.h5 = hptc_pkg::sx12(hum_ff[39:28]);
   end

   logic        pv, dv, halve;
   logic [31:0] ptemp, num, den, quo;
   logic [16:0] phum;
   hptc_pre u_pre (
      .clock, .reset, .in_valid(start && !busy),
      .raw_temp(req_raw_temp), .raw_pres(req_raw_pres), .raw_hum(req_raw_hum),
      .tc, .pc, .hc,
      .out_valid(pv), .out_temp(ptemp), .out_num(num), .out_den(den),
      .out_halve(halve), .out_hum(phum)
   );

   hptc_div u_div (
      .clock, .reset, .in_valid(pv), .in_num(num), .in_den(den),
      .out_valid(dv), .out_quo(quo)
   );

   localparam int D = hptc_pkg::DivBits;
   logic [D-1:0] hv_ff, zr_ff;
   logic [31:0]  dt_ff [D];
   logic [16:0]  dh_ff [D];
   always_ff @(posedge clock) begin
      hv_ff <= {hv_ff[D-2:0], halve};
      zr_ff <= {zr_ff[D-2:0], den == 32'd0};
      dt_ff[0] <= ptemp;
      dh_ff[0] <= phum;
      for (int i = 1; i < D; i++) begin
         dt_ff[i] <= dt_ff[i-1];
         dh_ff[i] <= dh_ff[i-1];
      end
   end

   hptc_post u_post (
      .clock, .reset, .in_valid(dv), .quo, .halve(hv_ff[D-1]), .zero(zr_ff[D-1]),
      .temp(dt_ff[D-1]), .hum(dh_ff[D-1]), .pc,
      .out_valid(rsp_valid), .out_temp(rsp_temp_centi), .out_pres(rsp_pres_pa),
      .out_hum(rsp_hum_q10), .out_err(rsp_div_error)
   );
endmodule

// File: rtl/hptc_div.sv
// pipelined restoring divider, one quotient bit per stage
module hptc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_num,
   input  logic [31:0] in_den,
   output logic        out_valid,
   output logic [31:0] out_quo
);
   localparam int N = hptc_pkg::DivBits;

   logic              vld_ff [1:N];
   logic [N-1:0]      num_ff [1:N];
   logic [N-1:0]      den_ff [1:N-1];
   logic [N-1:0]      rem_ff [1:N-1];

   for (genvar s = 0; s < N; s++) begin : g_st
      logic         vld_cur;
      logic [N-1:0] num_cur;
      logic [N-1:0] den_cur;
      logic [N-1:0] rem_cur;
      logic [N:0]   trial_in;
      logic [N:0]   diff_in;
      logic [N-1:0] rem_in;
      logic [N-1:0] num_in;
      if (s == 0) begin : g_head
         assign vld_cur = in_valid;
         assign num_cur = in_num;
         assign den_cur = in_den;
         assign rem_cur = '0;
      end else begin : g_body
         assign vld_cur = vld_ff[s];
         assign num_cur = num_ff[s];
         assign den_cur = den_ff[s];
         assign rem_cur = rem_ff[s];
      end
      always_comb begin
         trial_in = {rem_cur, num_cur[N-1]};
         diff_in  = trial_in - {1'b0, den_cur};
         if (!diff_in[N]) begin
            rem_in = diff_in[N-1:0];
            num_in = {num_cur[N-2:0], 1'b1};
         end else begin
            rem_in = trial_in[N-1:0];
            num_in = {num_cur[N-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else begin
            vld_ff[s+1] <= vld_cur;
         end
         num_ff[s+1] <= num_in;
      end
      if (s < N - 1) begin : g_carry
         always_ff @(posedge clock) begin
            den_ff[s+1] <= den_cur;
            rem_ff[s+1] <= rem_in;
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_quo   = num_ff[N];
endmodule

// File: rtl/hptc_pre.sv
// temperature, pressure divisor prep, humidity
module hptc_pre (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [19:0]              raw_temp,
   input  logic [19:0]              raw_pres,
   input  logic [15:0]              raw_hum,
   input  hptc_pkg::temp_coef_type  tc,
   input  hptc_pkg::pres_coef_type  pc,
   input  hptc_pkg::hum_coef_type   hc,
   output logic                     out_valid,
   output logic [31:0]              out_temp,
   output logic [31:0]              out_num,
   output logic [31:0]              out_den,
   output logic                     out_halve,
   output logic [16:0]              out_hum
);
   localparam int S = 10;
   logic [S:0]  v_ff;
   logic [31:0] temp_ff [S+1];

   // stage 1
   logic [31:0] rt, rp, rh;
   logic [31:0] ta_ff, dd_ff, rp1_ff, rh1_ff;
   assign rt = {12'd0, raw_temp};
   assign rp = {12'd0, raw_pres};
   assign rh = {16'd0, raw_hum};
   logic [31:0] d1;
   assign d1 = (rt >> 4) - tc.t1;
   // stage 2
   logic [31:0] ta2_ff, sq2_ff, rp2_ff, rh2_ff;
   // stage 3
   logic [31:0] fine3_ff, rp3_ff, rh3_ff;
   logic [31:0] tb3;
   // stage 4: a, hd
   logic [31:0] a4_ff, hd4_ff, rp4_ff, rh4_ff;
   logic [31:0] a3, hd3;
   // stage 5: products
   logic [31:0] d5_ff, ap5_ff, ap2_ff, dh6_ff, dh3_ff, h5d_ff, rp5_ff, rh5_ff;
   // stage 6
   logic [31:0] bq6_ff, p3d6_ff, ap5b_ff, ap2b_ff, hb6_ff, ha6_ff, rp6_ff;
   // stage 7
   logic [31:0] bp7_ff, ax7_ff, hb7_ff, ha7_ff, rp7_ff;
   // stage 8
   logic [31:0] am8_ff, hb8_ff, ha8_ff, bp8_ff, rp8_ff, hbs7;
   // stage 9
   logic [31:0] den9_ff, num9_ff, hum9_ff;
   logic [31:0] hs9;
   // stage 10
   logic [31:0] sq10_ff, hum10_ff, den10_ff, num10_ff;
   // stage 11: humidity clamp
   logic [31:0] temp11_ff, den11_ff, num11_ff;
   logic        halve11_ff;
   logic [16:0] hum11_ff;

   logic [31:0] numc;
   logic [31:0] humc, hq;
   assign tb3  = hptc_pkg::asr(hptc_pkg::asr(sq2_ff, 12) * tc.t3, 14);
   assign a3   = hptc_pkg::asr(fine3_ff, 1) - 32'd64000;
   assign hd3  = fine3_ff - 32'd76800;
   assign hbs7 = hptc_pkg::asr(hb7_ff, 10) + 32'd2097152;
   assign numc = ((32'd1048576 - rp8_ff) - hptc_pkg::asr(bp8_ff, 12)) * 32'd3125;
   assign hs9  = hptc_pkg::asr(hum9_ff, 15);
   assign humc = hum10_ff - hptc_pkg::asr(hptc_pkg::asr(sq10_ff, 7) * hc.h1, 4);
   always_comb begin
      if (humc[31]) hq = '0;
      else if (humc > 32'd419430400) hq = 32'd419430400;
      else hq = humc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[S-1:0], in_valid};
      end
      ta_ff  <= hptc_pkg::asr(((rt >> 3) - (tc.t1 << 1)) * tc.t2, 11);
      dd_ff  <= d1;
      rp1_ff <= rp;
      rh1_ff <= rh;
      ta2_ff <= ta_ff;
      sq2_ff <= dd_ff * dd_ff;
      rp2_ff <= rp1_ff;
      rh2_ff <= rh1_ff;
      fine3_ff <= ta2_ff + tb3;
      rp3_ff <= rp2_ff;
      rh3_ff <= rh2_ff;
      a4_ff  <= a3;
      hd4_ff <= hd3;
      temp_ff[4] <= hptc_pkg::asr(fine3_ff * 32'd5 + 32'd128, 8);
      rp4_ff <= rp3_ff;
      rh4_ff <= rh3_ff;
      d5_ff  <= hptc_pkg::asr(a4_ff, 2) * hptc_pkg::asr(a4_ff, 2);
      ap5_ff <= a4_ff * pc.p5;
      ap2_ff <= pc.p2 * a4_ff;
      dh6_ff <= hptc_pkg::asr(hd4_ff * hc.h6, 10);
      dh3_ff <= hptc_pkg::asr(hd4_ff * hc.h3, 11) + 32'd32768;
      h5d_ff <= hc.h5 * hd4_ff;
      temp_ff[5] <= temp_ff[4];
      rp5_ff <= rp4_ff;
      rh5_ff <= rh4_ff;
      bq6_ff  <= hptc_pkg::asr(d5_ff, 11) * pc.p6;
      p3d6_ff <= pc.p3 * hptc_pkg::asr(d5_ff, 13);
      ap5b_ff <= ap5_ff << 1;
      ap2b_ff <= hptc_pkg::asr(ap2_ff, 1);
      hb6_ff  <= dh6_ff * dh3_ff;
      ha6_ff  <= hptc_pkg::asr((rh5_ff << 14) - (hc.h4 << 20) - h5d_ff + 32'd16384, 15);
      temp_ff[6] <= temp_ff[5];
      rp6_ff <= rp5_ff;
      bp7_ff <= hptc_pkg::asr(bq6_ff + ap5b_ff, 2) + (pc.p4 << 16);
      ax7_ff <= hptc_pkg::asr(hptc_pkg::asr(p3d6_ff, 3) + ap2b_ff, 18);
      hb7_ff <= hb6_ff;
      ha7_ff <= ha6_ff;
      temp_ff[7] <= temp_ff[6];
      rp7_ff <= rp6_ff;
      am8_ff <= (32'd32768 + ax7_ff) * pc.p1;
      hb8_ff <= hptc_pkg::asr(hbs7 * hc.h2 + 32'd8192, 14);
      ha8_ff <= ha7_ff;
      bp8_ff <= bp7_ff;
      rp8_ff <= rp7_ff;
      temp_ff[8] <= temp_ff[7];
      den9_ff <= hptc_pkg::asr(am8_ff, 15);
      num9_ff <= numc;
      hum9_ff <= ha8_ff * hb8_ff;
      temp_ff[9] <= temp_ff[8];
      sq10_ff  <= hs9 * hs9;
      hum10_ff <= hum9_ff;
      den10_ff <= den9_ff;
      num10_ff <= num9_ff;
      temp_ff[10] <= temp_ff[9];
      hum11_ff   <= 17'(hq >> 12);
      temp11_ff  <= temp_ff[10];
      den11_ff   <= den10_ff;
      halve11_ff <= num10_ff[31];
      num11_ff   <= num10_ff[31] ? num10_ff : (num10_ff << 1);
   end

   assign out_valid = v_ff[S];
   assign out_temp  = temp11_ff;
   assign out_den   = den11_ff;
   assign out_halve = halve11_ff;
   assign out_num   = num11_ff;
   assign out_hum   = hum11_ff;
endmodule

// File: rtl/hptc_post.sv
// pressure correction after the divide
module hptc_post (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [31:0]             quo,
   input  logic                    halve,
   input  logic                    zero,
   input  logic [31:0]             temp,
   input  logic [16:0]             hum,
   input  hptc_pkg::pres_coef_type pc,
   output logic                    out_valid,
   output logic [31:0]             out_temp,
   output logic [31:0]             out_pres,
   output logic [16:0]             out_hum,
   output logic                    out_err
);
   logic [2:0]  v_ff;
   logic [31:0] p1_ff, p2_ff, sq1_ff, a2_ff, b2_ff, pr_ff;
   logic [31:0] t1_ff, t2_ff, t3_ff;
   logic [16:0] h1_ff, h2_ff, h3_ff;
   logic [2:0]  z_ff;
   logic [31:0] pres0, dq;
   assign pres0 = halve ? (quo << 1) : quo;
   assign dq    = pres0 >> 3;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[1:0], in_valid};
      end
      p1_ff  <= pres0;
      sq1_ff <= (dq * dq) >> 13;
      p2_ff  <= p1_ff;
      a2_ff  <= hptc_pkg::asr(pc.p9 * sq1_ff, 12);
      b2_ff  <= hptc_pkg::asr((p1_ff >> 2) * pc.p8, 13);
      pr_ff  <= p2_ff + hptc_pkg::asr(a2_ff + b2_ff + pc.p7, 4);
      z_ff   <= {z_ff[1:0], zero};
      t1_ff <= temp; t2_ff <= t1_ff; t3_ff <= t2_ff;
      h1_ff <= hum;  h2_ff <= h1_ff; h3_ff <= h2_ff;
   end

   assign out_valid = v_ff[2];
   assign out_temp  = t3_ff;
   assign out_pres  = z_ff[2] ? 32'd0 : pr_ff;
   assign out_hum   = h3_ff;
   assign out_err   = z_ff[2];
endmodule

// File: rtl/hptc_check.sv
module hptc_check (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        pready,
   input logic        rsp_valid,
   input logic [31:0] rsp_pres_pa,
   input logic [16:0] rsp_hum_q10,
   input logic        rsp_div_error
);
   a_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_ready: assert property (@(posedge clock) pready) else $error("pready low");
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_error |-> rsp_pres_pa == 32'd0)
      else $error("error with pressure");
   a_hum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hum_q10 <= 17'd102400)
      else $error("humidity out of range");
endmodule

bind humidity_pressure_temp_compensation_top hptc_check u_check (
   .clock, .reset, .busy, .pready, .rsp_valid, .rsp_pres_pa, .rsp_hum_q10, .rsp_div_error
);

// File: test/humidity_pressure_temp_compensation_checker.sv
module humidity_pressure_temp_compensation_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [19:0] req_raw_temp,
   input  logic [19:0] req_raw_pres,
   input  logic [15:0] req_raw_hum,
   input  logic        rsp_valid,
   input  logic [31:0] rsp_temp_centi,
   input  logic [31:0] rsp_pres_pa,
   input  logic [16:0] rsp_hum_q10,
   input  logic        rsp_div_error,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   input  logic        pready,
   output int          error_count,
   output int          pending
);

   typedef struct packed {
      logic [31:0] temp_centi;
      logic [31:0] pres_pa;
      logic [16:0] hum_q10;
      logic        div_error;
   } reading_type;

   logic [47:0] temp_cal;
   logic [63:0] pres_cal_a;
   logic [63:0] pres_cal_b;
   logic [39:0] misc_cal;
   logic [39:0] hum_cal;
   reading_type expected_readings[$];

   function automatic logic [31:0] sra(input logic [31:0] x, input int n);
      logic signed [31:0] s;
      s = x;
      return s >>> n;
   endfunction

   function automatic reading_type compensate(input logic [19:0] raw_t,
                                              input logic [19:0] raw_p,
                                              input logic [15:0] raw_h);
      logic [31:0] rt, rp, rh;
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
      logic [31:0] a, b, d, fine, pres, hum;
      reading_type r;
      rt = {12'b0, raw_t};
      rp = {12'b0, raw_p};
      rh = {16'b0, raw_h};
      t1 = {16'b0, temp_cal[15:0]};
      t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
      t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
      p1 = {16'b0, pres_cal_a[15:0]};
      p2 = {{16{pres_cal_a[31]}}, pres_cal_a[31:16]};
      p3 = {{16{pres_cal_a[47]}}, pres_cal_a[47:32]};
      p4 = {{16{pres_cal_a[63]}}, pres_cal_a[63:48]};
      p5 = {{16{pres_cal_b[15]}}, pres_cal_b[15:0]};
      p6 = {{16{pres_cal_b[31]}}, pres_cal_b[31:16]};
      p7 = {{16{pres_cal_b[47]}}, pres_cal_b[47:32]};
      p8 = {{16{pres_cal_b[63]}}, pres_cal_b[63:48]};
      p9 = {{16{misc_cal[15]}}, misc_cal[15:0]};
      h1 = {24'b0, misc_cal[23:16]};
      h3 = {24'b0, misc_cal[31:24]};
      h6 = {{24{misc_cal[39]}}, misc_cal[39:32]};
      h2 = {{16{hum_cal[15]}}, hum_cal[15:0]};
      h4 = {{20{hum_cal[27]}}, hum_cal[27:16]};
      h5 = {{20{hum_cal[39]}}, hum_cal[39:28]};

      a = sra(((rt >> 3) - (t1 << 1)) * t2, 11);
      d = (rt >> 4) - t1;
      b = sra(sra(d * d, 12) * t3, 14);
      fine = a + b;
      r.temp_centi = sra(fine * 5 + 128, 8);

      a = sra(fine, 1) - 32'd64000;
      d = sra(a, 2) * sra(a, 2);
      b = sra(d, 11) * p6;
      b = b + ((a * p5) << 1);
      b = sra(b, 2) + (p4 << 16);
      a = sra(sra(p3 * sra(d, 13), 3) + sra(p2 * a, 1), 18);
      a = sra((32'd32768 + a) * p1, 15);
      r.div_error = (a == 0);
      if (a == 0) begin
         pres = 0;
      end else begin
         pres = ((32'd1048576 - rp) - sra(b, 12)) * 32'd3125;
         if (pres < 32'h8000_0000) begin
            pres = (pres << 1) / a;
         end else begin
            pres = (pres / a) * 2;
         end
         d = pres >> 3;
         a = sra(p9 * ((d * d) >> 13), 12);
         b = sra((pres >> 2) * p8, 13);
         pres = pres + sra(a + b + p7, 4);
      end
      r.pres_pa = pres;

      d = fine - 32'd76800;
      a = sra((rh << 14) - (h4 << 20) - (h5 * d) + 32'd16384, 15);
      b = sra(d * h6, 10) * (sra(d * h3, 11) + 32'd32768);
      b = sra(b, 10) + 32'd2097152;
      b = sra(b * h2 + 32'd8192, 14);
      hum = a * b;
      a = sra(hum, 15);
      hum = hum - sra(sra(a * a, 7) * h1, 4);
      if (hum[31]) begin
         hum = 0;
      end else if (hum > 32'd419430400) begin
         hum = 32'd419430400;
      end
      hum = hum >> 12;
      r.hum_q10 = hum[16:0];
      return r;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t: mismatch %s got 0x%08h want 0x%08h", $realtime, what, got, want);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         temp_cal <= '0;
         pres_cal_a <= '0;
         pres_cal_b <= '0;
         misc_cal <= '0;
         hum_cal <= '0;
         expected_readings.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_readings.size() == 0) begin
               report("unexpected beat", rsp_pres_pa, 0);
            end else begin
               want = expected_readings.pop_front();
               if (rsp_temp_centi !== want.temp_centi)
                  report("temp_centi", rsp_temp_centi, want.temp_centi);
               if (rsp_pres_pa !== want.pres_pa)
                  report("pres_pa", rsp_pres_pa, want.pres_pa);
               if (rsp_hum_q10 !== want.hum_q10)
                  report("hum_q10", {15'd0, rsp_hum_q10}, {15'd0, want.hum_q10});
               if (rsp_div_error !== want.div_error)
                  report("div_error", {31'd0, rsp_div_error}, {31'd0, want.div_error});
            end
         end
         if (start && !busy)
            expected_readings.push_back(compensate(req_raw_temp, req_raw_pres, req_raw_hum));
         if (psel && penable && pwrite && pready) begin
            case (paddr[5:3])
               hptc_pkg::REG_TEMP:   temp_cal <= pwdata[47:0];
               hptc_pkg::REG_PRES_A: pres_cal_a <= pwdata;
               hptc_pkg::REG_PRES_B: pres_cal_b <= pwdata;
               hptc_pkg::REG_MISC:   misc_cal <= pwdata[39:0];
               hptc_pkg::REG_HUM:    hum_cal <= pwdata[39:0];
               default: ;
            endcase
         end
      end
      pending = expected_readings.size();
   end

endmodule

// File: test/humidity_pressure_temp_compensation_top_test.sv
module humidity_pressure_temp_compensation_top_test;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [19:0] req_raw_temp;
   logic [19:0] req_raw_pres;
   logic [15:0] req_raw_hum;
   logic        rsp_valid;
   logic [31:0] rsp_temp_centi;
   logic [31:0] rsp_pres_pa;
   logic [16:0] rsp_hum_q10;
   logic        rsp_div_error;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [5:0]  paddr;
   logic [63:0] pwdata;
   logic [63:0] prdata;
   logic        pready;
   int          error_count;
   int          pending;
   bit          quiet_tail;

   localparam int Latency = 46;

   humidity_pressure_temp_compensation_top u_top (.*);

   humidity_pressure_temp_compensation_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic csr_write(input hptc_pkg::reg_index_type idx, input logic [63:0] value);
      psel = 1;
      penable = 0;
      pwrite = 1;
      paddr = {idx, 3'b000};
      pwdata = value;
      @(negedge clock);
      penable = 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel = 0;
      penable = 0;
      pwrite = 0;
   endtask

   task automatic load_calibration(input logic [47:0] tc, input logic [63:0] pa,
                                   input logic [63:0] pb, input logic [39:0] mc,
                                   input logic [39:0] hc);
      csr_write(hptc_pkg::REG_TEMP, {16'hffff, tc});
      csr_write(hptc_pkg::REG_PRES_A, pa);
      csr_write(hptc_pkg::REG_PRES_B, pb);
      csr_write(hptc_pkg::REG_MISC, {24'hffffff, mc});
      csr_write(hptc_pkg::REG_HUM, {24'hffffff, hc});
   endtask

   task automatic drain();
      int n;
      n = 0;
      start = 0;
      while (pending != 0 && n < 10000) begin
         @(negedge clock);
         n++;
      end
      repeat (Latency + 10) @(negedge clock);
   endtask

   task automatic send_sample(input logic [19:0] t, input logic [19:0] p,
                              input logic [15:0] h);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         start = 0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      start = 1;
      req_raw_temp = t;
      req_raw_pres = p;
      req_raw_hum = h;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_samples(input int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            start = 0;
            while (pending != 0) @(negedge clock);
         end
         quiet_tail = (i > count - 40);
         case ($urandom_range(0, 3))
            0: send_sample(20'($urandom), 20'($urandom), 16'($urandom));
            default: send_sample(20'(519888 + $urandom_range(0, 60000) - 30000),
                                 20'(415148 + $urandom_range(0, 200000) - 100000),
                                 16'(30000 + $urandom_range(0, 30000) - 15000));
         endcase
      end
      quiet_tail = 0;
   endtask

   task automatic corner_samples();
      send_sample(20'h00000, 20'h00000, 16'h0000);
      send_sample(20'hfffff, 20'hfffff, 16'hffff);
      send_sample(20'hfffff, 20'h00000, 16'h0000);
      send_sample(20'h00000, 20'hfffff, 16'hffff);
      send_sample(20'h80000, 20'h80000, 16'h8000);
      send_sample(20'h55555, 20'haaaaa, 16'h5555);
      send_sample(20'd519888, 20'd415148, 16'd30000);
      send_sample(20'd519888, 20'd415148, 16'd65535);
   endtask

   initial begin
      reset = 1;
      start = 0;
      req_raw_temp = '0;
      req_raw_pres = '0;
      req_raw_hum = '0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = '0;
      pwdata = '0;
      quiet_tail = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // all-zero calibration: divisor is zero
      corner_samples();
      drain();

      load_calibration({16'hfc18, 16'd26435, 16'd27504},
                       {16'd2855, 16'd3024, 16'hd643, 16'd36477},
                       {16'hc6f8, 16'd15500, 16'hfff9, 16'd140},
                       {8'd30, 8'd0, 8'd75, 16'd6000},
                       {12'd50, 12'd324, 16'd362});
      corner_samples();
      random_samples(600);
      drain();

      load_calibration('1, '1, '1, '1, '1);
      corner_samples();
      random_samples(150);
      drain();

      load_calibration({16'h7fff, 16'h8000, 16'hffff}, {4{16'h8000}}, {4{16'h7fff}},
                       {8'h80, 8'hff, 8'hff, 16'h8000}, {12'h7ff, 12'h800, 16'h7fff});
      random_samples(100);
      drain();

      for (int k = 0; k < 4; k++) begin
         load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                          {$urandom, $urandom}, 40'({$urandom, $urandom}),
                          40'({$urandom, $urandom}));
         random_samples(100);
         drain();
      end

      // write outside the register map, then a realistic set again
      psel = 1;
      pwrite = 1;
      paddr = 6'd40;
      pwdata = '1;
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0;
      penable = 0;
      pwrite = 0;
      load_calibration({16'hfc18, 16'd26435, 16'd27504},
                       {16'd2855, 16'd3024, 16'hd643, 16'd36477},
                       {16'hc6f8, 16'd15500, 16'hfff9, 16'd140},
                       {8'hf6, 8'd200, 8'd75, 16'd6000},
                       {12'hf38, 12'd324, 16'd362});
      random_samples(350);
      drain();

      if (error_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
